/* rtl/bit_sliced_crossbar_mvm_core_defines.svh */
// ----------------------------------------------------------------------------
// Bit-sliced crossbar MVM core: assertion macros
// Implication helpers; they expand to nothing in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef BIT_SLICED_CROSSBAR_MVM_CORE_DEFINES_SVH
`define BIT_SLICED_CROSSBAR_MVM_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define BSCM_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("bscm: assertion failed");
// next-cycle implication
`define BSCM_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("bscm: assertion failed");
`else
`define BSCM_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define BSCM_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

/* rtl/bscm_pkg.sv */
// ----------------------------------------------------------------------------
// bscm_pkg
// Shared constants, types and slice-plan helpers of the crossbar MVM core.
// ----------------------------------------------------------------------------
`default_nettype none
package bscm_pkg;

  localparam int Rows   = 64;
  localparam int Cols   = 64;
  localparam int Slices = 4;
  localparam int WBit   = 8;
  localparam int IBit   = 8;

  localparam int RowW   = $clog2(Rows);
  localparam int ColW   = $clog2(Cols);
  localparam int SliceW = $clog2(Slices);
  localparam int AddrW  = RowW + SliceW + ColW;

  // mapping modes
  localparam logic [2:0] MODE_DIFF    = 3'd0;
  localparam logic [2:0] MODE_OFS_IN  = 3'd1;
  localparam logic [2:0] MODE_TWOS_IN = 3'd2;
  localparam logic [2:0] MODE_UNS_IN  = 3'd3;
  localparam logic [2:0] MODE_OFS_W   = 3'd4;

  // register indexes
  localparam logic [3:0] REG_MODE = 4'd0;
  localparam logic [3:0] REG_ROWS = 4'd1;
  localparam logic [3:0] REG_COLS = 4'd2;
  localparam logic [3:0] REG_NSL  = 4'd3;
  localparam logic [3:0] REG_SW0  = 4'd4;
  localparam logic [3:0] REG_SW1  = 4'd5;
  localparam logic [3:0] REG_SW2  = 4'd6;
  localparam logic [3:0] REG_SW3  = 4'd7;

  typedef logic [Slices-1:0][3:0] shift_vec_t;

  // tag that travels with one memory read into the MAC
  typedef struct packed {
    logic       valid;
    logic [3:0] shift;
    logic       sum_en;   // element belongs to the input-sum pass
  } mac_tag_t;

  function automatic logic [3:0] clamp_width(input logic [3:0] sw);
    clamp_width = (sw > 4'd8) ? 4'd8 : sw;
  endfunction

  function automatic logic [7:0] slice_mask(input logic [3:0] sw);
    logic [3:0] w;
    w = clamp_width(sw);
    slice_mask = (w == 4'd8) ? 8'hFF : 8'((9'd1 << w) - 9'd1);
  endfunction

  // shift of each slice: remaining bits minus width, floored at zero
  function automatic shift_vec_t slice_shifts(input logic [Slices-1:0][3:0] sw);
    logic [3:0] cur;
    logic [3:0] w;
    cur = 4'(WBit);
    for (int s = 0; s < Slices; s++) begin
      w = clamp_width(sw[s]);
      cur = (cur >= w) ? cur - w : 4'd0;
      slice_shifts[s] = cur;
    end
  endfunction

endpackage
`default_nettype wire

/* rtl/bscm_mac.sv */
// ----------------------------------------------------------------------------
// bscm_mac
// Slice-times-input product and shifted accumulation, plus the input sum.
// ----------------------------------------------------------------------------
`default_nettype none
module bscm_mac (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic [2:0]          mode_i,
  input  wire bscm_pkg::mac_tag_t  tag_i,
  input  wire logic [7:0]          pos_i,
  input  wire logic [7:0]          neg_i,
  input  wire logic signed [8:0]   vec_i,
  input  wire logic                clr_acc_i,
  input  wire logic                clr_sum_i,
  output logic                     busy_o,
  output logic [31:0]              acc_o,
  output logic [14:0]              isum_o
);

  logic signed [8:0]  w_s;
  logic signed [9:0]  x_s;
  logic signed [18:0] prod;

  logic               p2_valid_q;
  logic signed [18:0] prod_q;
  logic [3:0]         sh_q;
  logic               sum_en_q;
  logic signed [8:0]  v_q;
  logic [31:0]        acc_q;
  logic [14:0]        isum_q;

  assign w_s = (mode_i == bscm_pkg::MODE_OFS_W) ? $signed({1'b0, pos_i})
             : $signed({1'b0, pos_i}) - $signed({1'b0, neg_i});

  always_comb begin
    case (mode_i)
      bscm_pkg::MODE_OFS_IN:  x_s = 10'sd128 + $signed({vec_i[8], vec_i});
      bscm_pkg::MODE_TWOS_IN: x_s = $signed({3'b000, vec_i[6:0]})
                                  - $signed({2'b00, vec_i[7], 7'b0});
      default:                x_s = $signed({vec_i[8], vec_i});
    endcase
  end

  assign prod = w_s * x_s;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p2_valid_q <= 1'b0;
    end else begin
      p2_valid_q <= tag_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q   <= prod;
    sh_q     <= tag_i.shift;
    sum_en_q <= tag_i.sum_en;
    v_q      <= vec_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      isum_q <= '0;
    end else begin
      if (clr_acc_i) begin
        acc_q <= '0;
      end else if (p2_valid_q) begin
        acc_q <= acc_q + ({{13{prod_q[18]}}, prod_q} << sh_q);
      end
      if (clr_sum_i) begin
        isum_q <= '0;
      end else if (p2_valid_q && sum_en_q) begin
        isum_q <= isum_q + {{6{v_q[8]}}, v_q};
      end
    end
  end

  assign busy_o = p2_valid_q;
  assign acc_o  = acc_q;
  assign isum_o = isum_q;

endmodule
`default_nettype wire

/* rtl/bit_sliced_crossbar_mvm_core.sv */
// ----------------------------------------------------------------------------
// bit_sliced_crossbar_mvm_core
// Bit-sliced weight store with sequential matrix-vector product per row.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake              | content
//  s_axis   | in        | s_axis_tvalid/tready   | weight write or vector element
//  m_axis   | out       | m_axis_tvalid/tready   | one row result per transaction
//  cfg      | in        | cfg_valid_i/cfg_ready_o| register index + data
//
//  After reset a clearing pass over all slice-memory addresses zeroes the slice
//  memories and the row weight sums; no input transaction is taken during it.
//  A weight write is accepted and then stored one slice after another through
//  the single write port of the slice memories; s_axis is not ready meanwhile.
//  A vector element is stored as it is accepted.
//  The last element starts the product: per row, one memory word per cycle
//  over slices x columns, then the pipeline drains and the row result is
//  emitted, for each of rows_used rows.
//  A stalled m_axis holds the sequencer at the row boundary.
// ----------------------------------------------------------------------------
`default_nettype none
`include "bit_sliced_crossbar_mvm_core_defines.svh"
module bit_sliced_crossbar_mvm_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,  // row[5:0], col[11:6], value[20:12], zero pad
  input  wire logic [0:0]  s_axis_tuser,  // func[0]
  input  wire logic        s_axis_tlast,  // last
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,  // out_row[5:0], dot_result[37:6], zero pad
  output logic             m_axis_tlast,  // out_last
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [3:0]  cfg_index_i,
  input  wire logic [7:0]  cfg_data_i
);

  localparam logic [2:0] ST_CLR   = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_WR    = 3'd2;
  localparam logic [2:0] ST_RUN   = 3'd3;
  localparam logic [2:0] ST_DRAIN = 3'd4;
  localparam logic [2:0] ST_EMIT  = 3'd5;

  localparam int RwsW = 25;  // sums kept modulo 2^25, enough for the << 7 correction

  // ---------------- configuration ----------------
  logic [2:0] mode_q;
  logic [6:0] rows_q, cols_q;
  logic [2:0] nsl_q;
  logic [bscm_pkg::Slices-1:0][3:0] sw_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= bscm_pkg::MODE_DIFF;
      rows_q <= 7'd64;
      cols_q <= 7'd64;
      nsl_q  <= 3'd1;
      sw_q   <= {4'd1, 4'd1, 4'd1, 4'd8};
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        bscm_pkg::REG_MODE: mode_q   <= cfg_data_i[2:0];
        bscm_pkg::REG_ROWS: rows_q   <= cfg_data_i[6:0];
        bscm_pkg::REG_COLS: cols_q   <= cfg_data_i[6:0];
        bscm_pkg::REG_NSL:  nsl_q    <= cfg_data_i[2:0];
        bscm_pkg::REG_SW0:  sw_q[0]  <= cfg_data_i[3:0];
        bscm_pkg::REG_SW1:  sw_q[1]  <= cfg_data_i[3:0];
        bscm_pkg::REG_SW2:  sw_q[2]  <= cfg_data_i[3:0];
        bscm_pkg::REG_SW3:  sw_q[3]  <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // effective settings: out-of-range counts saturate, an unknown mode falls back to MODE_DIFF
  logic [2:0] mode;
  logic [2:0] ns;
  logic [6:0] nr, nc;
  bscm_pkg::shift_vec_t shifts;

  assign mode   = (mode_q > bscm_pkg::MODE_OFS_W) ? bscm_pkg::MODE_DIFF : mode_q;
  assign ns     = (nsl_q == 3'd0) ? 3'd1 : ((nsl_q > 3'd4) ? 3'd4 : nsl_q);
  assign nr     = (rows_q == 7'd0) ? 7'd1 : ((rows_q > 7'd64) ? 7'd64 : rows_q);
  assign nc     = (cols_q == 7'd0) ? 7'd1 : ((cols_q > 7'd64) ? 7'd64 : cols_q);
  assign shifts = bscm_pkg::slice_shifts(sw_q);

  // ---------------- input decode ----------------
  logic       in_acc;
  logic [5:0] in_row, in_col;
  logic [8:0] in_val;

  assign in_row = s_axis_tdata[5:0];
  assign in_col = s_axis_tdata[11:6];
  assign in_val = s_axis_tdata[20:12];
  assign in_acc = s_axis_tvalid && s_axis_tready;

  // ---------------- control state ----------------
  logic [2:0]  state_q, state_d;
  logic [13:0] clr_q;
  logic [5:0]  r_q, c_q;
  logic [1:0]  s_q;
  logic [5:0]  w_row_q, w_col_q;
  logic [8:0]  w_val_q;
  logic        m_valid_q;
  logic [5:0]  m_row_q;
  logic [31:0] m_dot_q;
  logic        m_last_q;

  logic slice_end, col_end, row_end, out_load;
  assign slice_end = ({1'b0, s_q} == ns - 3'd1);
  assign col_end   = ({1'b0, c_q} == nc - 7'd1);
  assign row_end   = ({1'b0, r_q} == nr - 7'd1);
  assign out_load  = (state_q == ST_EMIT) && (!m_valid_q || m_axis_tready);

  assign s_axis_tready = (state_q == ST_IDLE);

  // ---------------- memories ----------------
  logic [7:0]        pos_mem [1 << bscm_pkg::AddrW];
  logic [7:0]        neg_mem [1 << bscm_pkg::AddrW];
  logic [8:0]        vec_mem [bscm_pkg::Cols];
  logic [RwsW-1:0]   rws_mem [bscm_pkg::Rows];

  logic [bscm_pkg::AddrW-1:0] sl_waddr, sl_raddr;
  logic                       pos_we, neg_we;
  logic [7:0]                 pos_wd, neg_wd;
  logic [7:0]                 pos_rd_q, neg_rd_q;
  logic [8:0]                 vec_rd_q;
  logic [5:0]                 rws_raddr, rws_waddr;
  logic                       rws_we;
  logic [RwsW-1:0]            rws_wd, rws_rd_q;

  // weight slice value: weight, its magnitude, or biased weight, arithmetic shift
  logic signed [9:0]  wsrc;
  logic signed [17:0] wsh;
  logic [7:0]         wslice;
  logic               w_neg;

  assign w_neg = w_val_q[8];
  always_comb begin
    if (mode == bscm_pkg::MODE_OFS_W) begin
      wsrc = $signed({w_val_q[8], w_val_q}) + 10'sd128;
    end else if (w_neg) begin
      wsrc = 10'sd0 - $signed({w_val_q[8], w_val_q});
    end else begin
      wsrc = $signed({w_val_q[8], w_val_q});
    end
  end
  assign wsh    = $signed({{8{wsrc[9]}}, wsrc}) >>> shifts[s_q];
  assign wslice = wsh[7:0] & bscm_pkg::slice_mask(sw_q[s_q]);

  always_comb begin
    sl_waddr = {w_row_q, s_q, w_col_q};
    pos_we   = 1'b0;
    neg_we   = 1'b0;
    pos_wd   = 8'd0;
    neg_wd   = 8'd0;
    rws_we   = 1'b0;
    rws_waddr = w_row_q;
    rws_wd   = (w_col_q == 6'd0) ? {{(RwsW-9){w_val_q[8]}}, w_val_q}
                                 : rws_rd_q + {{(RwsW-9){w_val_q[8]}}, w_val_q};
    if (state_q == ST_CLR) begin
      sl_waddr  = clr_q;
      pos_we    = 1'b1;
      neg_we    = 1'b1;
      rws_we    = (clr_q < 14'(bscm_pkg::Rows));
      rws_waddr = clr_q[5:0];
      rws_wd    = '0;
    end else if (state_q == ST_WR) begin
      pos_we = 1'b1;
      neg_we = (mode != bscm_pkg::MODE_OFS_W);
      if (mode == bscm_pkg::MODE_OFS_W || !w_neg) begin
        pos_wd = wslice;
      end else begin
        neg_wd = wslice;
      end
      rws_we = slice_end && (mode == bscm_pkg::MODE_OFS_IN);
    end
  end

  assign sl_raddr  = {r_q, s_q, c_q};
  assign rws_raddr = (state_q == ST_IDLE) ? in_row
                   : ((state_q == ST_WR) ? w_row_q : r_q);

  always_ff @(posedge clk_i) begin
    if (pos_we) pos_mem[sl_waddr] <= pos_wd;
    if (neg_we) neg_mem[sl_waddr] <= neg_wd;
    pos_rd_q <= pos_mem[sl_raddr];
    neg_rd_q <= neg_mem[sl_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && s_axis_tuser[0]) vec_mem[in_col] <= in_val;
    vec_rd_q <= vec_mem[c_q];
  end

  always_ff @(posedge clk_i) begin
    if (rws_we) rws_mem[rws_waddr] <= rws_wd;
    rws_rd_q <= rws_mem[rws_raddr];
  end

  // ---------------- MAC pipeline ----------------
  bscm_pkg::mac_tag_t p1_q;
  logic               start;
  logic               mac_busy;
  logic [31:0]        acc;
  logic [14:0]        isum;

  assign start = in_acc && s_axis_tuser[0] && s_axis_tlast;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_q <= '0;
    end else begin
      p1_q.valid  <= (state_q == ST_RUN);
      p1_q.shift  <= shifts[s_q];
      p1_q.sum_en <= (r_q == 6'd0) && (s_q == 2'd0);
    end
  end

  bscm_mac u_mac (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .mode_i    (mode),
    .tag_i     (p1_q),
    .pos_i     (pos_rd_q),
    .neg_i     (neg_rd_q),
    .vec_i     ($signed(vec_rd_q)),
    .clr_acc_i (start || out_load),
    .clr_sum_i (start),
    .busy_o    (mac_busy),
    .acc_o     (acc),
    .isum_o    (isum)
  );

  // row-end corrections
  logic [31:0] corr, result;
  always_comb begin
    case (mode)
      bscm_pkg::MODE_OFS_IN: corr = {rws_rd_q, 7'b0};
      bscm_pkg::MODE_OFS_W:  corr = {{10{isum[14]}}, isum, 7'b0};
      default:               corr = 32'd0;
    endcase
  end
  assign result = acc - corr;

  // ---------------- sequencer ----------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLR:   if (clr_q == '1) state_d = ST_IDLE;
      ST_IDLE: begin
        if (in_acc && !s_axis_tuser[0]) state_d = ST_WR;
        else if (start) state_d = ST_RUN;
      end
      ST_WR:    if (slice_end) state_d = ST_IDLE;
      ST_RUN:   if (slice_end && col_end) state_d = ST_DRAIN;
      ST_DRAIN: if (!p1_q.valid && !mac_busy) state_d = ST_EMIT;
      ST_EMIT:  if (out_load) state_d = row_end ? ST_IDLE : ST_RUN;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLR;
      clr_q   <= '0;
      r_q     <= '0;
      s_q     <= '0;
      c_q     <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLR) clr_q <= clr_q + 14'd1;
      case (state_q)
        ST_IDLE: begin
          r_q <= '0;
          s_q <= '0;
          c_q <= '0;
        end
        ST_WR: s_q <= slice_end ? 2'd0 : s_q + 2'd1;
        ST_RUN: begin
          if (col_end) begin
            c_q <= '0;
            s_q <= slice_end ? 2'd0 : s_q + 2'd1;
          end else begin
            c_q <= c_q + 6'd1;
          end
        end
        ST_EMIT: if (out_load) r_q <= r_q + 6'd1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && !s_axis_tuser[0]) begin
      w_row_q <= in_row;
      w_col_q <= in_col;
      w_val_q <= in_val;
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_row_q  <= r_q;
      m_dot_q  <= result;
      m_last_q <= row_end;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {2'b00, m_dot_q, m_row_q};
  assign m_axis_tlast  = m_last_q;

  // ---------------- assertions ----------------
  `BSCM_ASSERT_IMP(a_ready_pipe_empty, clk_i, rst_ni, s_axis_tready, !p1_q.valid && !mac_busy)
  `BSCM_ASSERT_IMP(a_run_in_range, clk_i, rst_ni, state_q == ST_RUN, ({1'b0, r_q} < nr) && ({1'b0, c_q} < nc))
  `BSCM_ASSERT_IMP(a_clr_no_output, clk_i, rst_ni, state_q == ST_CLR, !m_valid_q)
  `BSCM_ASSERT_NXT(a_emit_next_row, clk_i, rst_ni, out_load && !row_end, state_q == ST_RUN)

endmodule
`default_nettype wire
